// File: design/rlmpd_pkg.sv
// ----------------------------------------------------------------------------
// rlmpd_pkg
// Shared widths, register codes, reset values and types of the raster
// local maximum peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package rlmpd_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int ROW_LIMIT     = 4096;

  localparam int MERIT_W    = 32;
  localparam int ANGLE_W    = 12;
  localparam int COORD_W    = 12;
  localparam int TAG_W      = 8;
  localparam int DIM_W      = 13;
  localparam int MARGIN_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH       = 3'd0,
    REG_MAP_HEIGHT      = 3'd1,
    REG_BORDER_MARGIN   = 3'd2,
    REG_MERIT_THRESHOLD = 3'd3,
    REG_REFERENCE_TAG   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]    map_width;
    logic [DIM_W-1:0]    map_height;
    logic [MARGIN_W-1:0] border_margin;
    logic [MERIT_W-1:0]  merit_threshold;
    logic [TAG_W-1:0]    reference_tag;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    map_width:       DIM_W'(4096),
    map_height:      DIM_W'(4096),
    border_margin:   MARGIN_W'(1),
    merit_threshold: MERIT_W'(16384),
    reference_tag:   TAG_W'(0)
  };

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [ANGLE_W-1:0] angle;
    logic [MERIT_W-1:0] merit;
    logic [TAG_W-1:0]   tag;
  } peak_t;

  // lo <= x <= centre, signed Q16.16 patterns
  function automatic logic in_band(input logic [MERIT_W-1:0] lo,
                                   input logic [MERIT_W-1:0] x,
                                   input logic [MERIT_W-1:0] hi);
    return ($signed(lo) <= $signed(x)) && ($signed(x) <= $signed(hi));
  endfunction

endpackage

`default_nettype wire

// File: design/rlmpd_if.sv
// ----------------------------------------------------------------------------
// rlmpd interfaces
// Valid/ready channels for pixels in, peaks out and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlmpd_pixel_if;
  import rlmpd_pkg::*;
  logic               valid;
  logic               ready;
  logic [MERIT_W-1:0] merit;
  logic [ANGLE_W-1:0] angle;
  modport source (output valid, merit, angle, input ready);
  modport sink   (input valid, merit, angle, output ready);
endinterface

interface rlmpd_peak_if;
  import rlmpd_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [ANGLE_W-1:0] peak_angle;
  logic [MERIT_W-1:0] peak_merit;
  logic [TAG_W-1:0]   peak_reference;
  modport source (output valid, col, row, peak_angle, peak_merit, peak_reference,
                  input ready);
  modport sink   (input valid, col, row, peak_angle, peak_merit, peak_reference,
                  output ready);
endinterface

interface rlmpd_cfg_if;
  import rlmpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/rlmpd_line_mem.sv
// ----------------------------------------------------------------------------
// rlmpd_line_mem
// One line store: single write port, single read port, registered read data,
// read returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmpd_line_mem #(
  parameter int DEPTH  = rlmpd_pkg::MAX_WIDTH_DEF,
  parameter int DATA_W = rlmpd_pkg::MERIT_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/rlmpd_peak_fifo.sv
// ----------------------------------------------------------------------------
// rlmpd_peak_fifo
// Small output queue of found peaks; its head drives the peak channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmpd_peak_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  rlmpd_pkg::peak_t                push_data,
  input  logic                            pop,
  output logic                            out_valid,
  output rlmpd_pkg::peak_t                out_data,
  output logic [rlmpd_pkg::FIFO_CNT_W-1:0] count
);
  import rlmpd_pkg::*;

  peak_t                 entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];

endmodule

`default_nettype wire

// File: design/rlmpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rlmpd_cfg_regs
// Register file: decodes writes on the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmpd_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  rlmpd_cfg_if.sink      cfg,
  output rlmpd_pkg::cfg_t regs
);
  import rlmpd_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_MAP_WIDTH:       regs.map_width       <= cfg.data[DIM_W-1:0];
        REG_MAP_HEIGHT:      regs.map_height      <= cfg.data[DIM_W-1:0];
        REG_BORDER_MARGIN:   regs.border_margin   <= cfg.data[MARGIN_W-1:0];
        REG_MERIT_THRESHOLD: regs.merit_threshold <= cfg.data[MERIT_W-1:0];
        REG_REFERENCE_TAG:   regs.reference_tag   <= cfg.data[TAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/raster_local_max_peak_detect_top.sv
// ----------------------------------------------------------------------------
// raster_local_max_peak_detect_top
// Thresholded 4-neighbour local maximum search over a raster merit map.
// ----------------------------------------------------------------------------
// Usage:
//   pixel : one item per pixel (merit, angle), row order, column fastest.
//   peak  : one item per peak found (col, row, peak_angle, peak_merit,
//           peak_reference), in raster order of the peak pixel.
//   cfg   : register writes (index, data), always ready; write only while
//           the block is idle.
// A pixel is judged when the pixel directly below it is taken; its peak
// item passes the judge stage registers into the output queue.
// Throughput is one pixel per cycle while ready: line stores are read in
// the accept cycle and judged in the next, the above store being written
// back then with forwarding to a following read of the same column.
// Peaks wait in a four-entry output queue; pixel.ready drops only when the
// queue plus the item being judged would fill it, so a stalled receiver
// holds the upstream after a few items, and nothing is dropped.
// Reset clears position counters, registers and the queue at once; the
// line stores are not cleared, as the first row of a map only fills them.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_local_max_peak_detect_top #(
  parameter int MAX_WIDTH = rlmpd_pkg::MAX_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rlmpd_pixel_if.sink   pixel,
  rlmpd_peak_if.source  peak,
  rlmpd_cfg_if.sink     cfg
);
  import rlmpd_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int GEO_W = (CNT_W + 2 > 14) ? CNT_W + 2 : 14;
  localparam int SUM_W = FIFO_CNT_W + 1;
  localparam logic [GEO_W-1:0] GEO_ONE = GEO_W'(1);

  cfg_t regs;

  logic [CNT_W-1:0]   col_count;
  logic [COORD_W-1:0] row_count;

  logic [GEO_W-1:0] w_raw, h_raw, w_eff, h_eff, m_eff;
  logic [GEO_W-1:0] c_geo, r_geo;
  logic             pos_ok, col_last, row_last, accept;

  // judge stage
  logic               s1_valid;
  logic [CNT_W-1:0]   s1_col;
  logic [COORD_W-1:0] s1_row;
  logic [MERIT_W-1:0] s1_px;
  logic               s1_pos_ok;

  logic [MERIT_W-1:0] cen_c, cen_n, abv_c_mem, abv_p_mem, abv_c, abv_p;
  logic [ANGLE_W-1:0] ang_c;
  logic               fwd_c, fwd_p;
  logic [MERIT_W-1:0] fwd_data;

  logic                  is_peak;
  peak_t                 push_data, head;
  logic                  head_valid, pop;
  logic [FIFO_CNT_W-1:0] fifo_count;

  rlmpd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // effective geometry
  always_comb begin
    w_raw = GEO_W'(regs.map_width);
    h_raw = GEO_W'(regs.map_height);
    if (w_raw > GEO_W'(MAX_WIDTH)) begin
      w_eff = GEO_W'(MAX_WIDTH);
    end else if (w_raw == '0) begin
      w_eff = GEO_ONE;
    end else begin
      w_eff = w_raw;
    end
    if (h_raw > GEO_W'(ROW_LIMIT)) begin
      h_eff = GEO_W'(ROW_LIMIT);
    end else if (h_raw == '0) begin
      h_eff = GEO_ONE;
    end else begin
      h_eff = h_raw;
    end
    m_eff = (regs.border_margin == '0) ? GEO_ONE : GEO_W'(regs.border_margin);
  end

  assign c_geo    = GEO_W'(col_count);
  assign r_geo    = GEO_W'(row_count);
  // centre pixel sits at (row_count - 1, col_count)
  assign pos_ok   = (c_geo >= m_eff) && (c_geo + m_eff + GEO_ONE <= w_eff) &&
                    (r_geo >= m_eff + GEO_ONE) && (r_geo + m_eff <= h_eff);
  assign col_last = (c_geo + GEO_ONE >= w_eff);
  assign row_last = (r_geo + GEO_ONE >= h_eff);

  assign accept      = pixel.valid && pixel.ready;
  assign pixel.ready = (SUM_W'(fifo_count) + SUM_W'(s1_valid)) < SUM_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_count <= '0;
        row_count <= row_last ? '0 : row_count + COORD_W'(1);
      end else begin
        col_count <= col_count + CNT_W'(1);
      end
    end
  end

  // centre stores take the new pixel at once; a read of the same entry
  // in that cycle still sees the previous row
  rlmpd_line_mem #(.DEPTH(MAX_WIDTH), .DATA_W(MERIT_W)) u_centre_c (
    .clk   (clk),
    .we    (accept),
    .waddr (col_count),
    .wdata (pixel.merit),
    .raddr (col_count),
    .rdata (cen_c)
  );

  rlmpd_line_mem #(.DEPTH(MAX_WIDTH), .DATA_W(MERIT_W)) u_centre_n (
    .clk   (clk),
    .we    (accept),
    .waddr (col_count),
    .wdata (pixel.merit),
    .raddr (col_count + CNT_W'(1)),
    .rdata (cen_n)
  );

  rlmpd_line_mem #(.DEPTH(MAX_WIDTH), .DATA_W(ANGLE_W)) u_angle (
    .clk   (clk),
    .we    (accept),
    .waddr (col_count),
    .wdata (pixel.angle),
    .raddr (col_count),
    .rdata (ang_c)
  );

  // above store is written back from the judge stage
  rlmpd_line_mem #(.DEPTH(MAX_WIDTH), .DATA_W(MERIT_W)) u_above_c (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (cen_c),
    .raddr (col_count),
    .rdata (abv_c_mem)
  );

  rlmpd_line_mem #(.DEPTH(MAX_WIDTH), .DATA_W(MERIT_W)) u_above_p (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (cen_c),
    .raddr (col_count - CNT_W'(1)),
    .rdata (abv_p_mem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_c    <= 1'b0;
      fwd_p    <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd_c    <= s1_valid && (s1_col == col_count);
      fwd_p    <= s1_valid && (s1_col == col_count - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    s1_col    <= col_count;
    s1_row    <= row_count;
    s1_px     <= pixel.merit;
    s1_pos_ok <= pos_ok;
    fwd_data  <= cen_c;
  end

  assign abv_c = fwd_c ? fwd_data : abv_c_mem;
  assign abv_p = fwd_p ? fwd_data : abv_p_mem;

  always_comb begin
    is_peak = s1_valid && s1_pos_ok &&
              ($signed(regs.merit_threshold) <= $signed(cen_c)) &&
              in_band(regs.merit_threshold, abv_c, cen_c) &&
              in_band(regs.merit_threshold, s1_px, cen_c) &&
              in_band(regs.merit_threshold, abv_p, cen_c) &&
              in_band(regs.merit_threshold, cen_n, cen_c);
    push_data.col   = COORD_W'(s1_col);
    push_data.row   = s1_row - COORD_W'(1);
    push_data.angle = ang_c;
    push_data.merit = cen_c;
    push_data.tag   = regs.reference_tag;
  end

  assign pop = head_valid && peak.ready;

  rlmpd_peak_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (is_peak),
    .push_data (push_data),
    .pop       (pop),
    .out_valid (head_valid),
    .out_data  (head),
    .count     (fifo_count)
  );

  assign peak.valid          = head_valid;
  assign peak.col            = head.col;
  assign peak.row            = head.row;
  assign peak.peak_angle     = head.angle;
  assign peak.peak_merit     = head.merit;
  assign peak.peak_reference = head.tag;

endmodule

`default_nettype wire

// File: design/rlmpd_checker.sv
// ----------------------------------------------------------------------------
// rlmpd_checker
// Port-level checks of the peak detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmpd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rlmpd_pkg::COORD_W-1:0] out_col,
  input logic [rlmpd_pkg::COORD_W-1:0] out_row,
  input logic [rlmpd_pkg::ANGLE_W-1:0] out_angle,
  input logic [rlmpd_pkg::MERIT_W-1:0] out_merit,
  input logic [rlmpd_pkg::TAG_W-1:0]   out_tag
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("peak item withdrawn before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_col) && $stable(out_row) &&
      $stable(out_angle) && $stable(out_merit) && $stable(out_tag))
    else $error("stalled peak item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("peak valid right after reset");

  // a newly valid peak needs a pixel taken earlier, through the judge stage and the queue
  a_peak_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("peak item without a pixel behind it");

  // the margin is at least one, so no peak on the first row or column
  a_peak_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_col != '0) && (out_row != '0))
    else $error("peak item on the map edge");

endmodule

bind raster_local_max_peak_detect_top rlmpd_checker u_rlmpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .out_valid (peak.valid),
  .out_ready (peak.ready),
  .out_col   (peak.col),
  .out_row   (peak.row),
  .out_angle (peak.peak_angle),
  .out_merit (peak.peak_merit),
  .out_tag   (peak.peak_reference)
);

`default_nettype wire
